// ===== rtl/core/dwld_pkg.sv =====
// Package for the diamond window label dilation block.
// Holds register indexes and input action codes; no dependencies.
package dwld_pkg;
	localparam logic [1:0] REG_DIST    = 2'd0;
	localparam logic [1:0] REG_SAMPLES = 2'd1;
	localparam logic [1:0] REG_LINES   = 2'd2;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
endpackage

// ===== rtl/core/dwld_queue.sv =====
// Small job queue between the front and back parts of the dilation block.
// Generic over word width and depth; no package dependencies.
module dwld_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB = $clog2(DEPTH + 1);

	logic [W-1:0]  slots_q [DEPTH];
	logic [PB-1:0] wr_ptr_q, rd_ptr_q;
	logic [CB-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CB'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/dwld_front.sv =====
// Front part: accepts input items, keeps the input and output position counters,
// writes pixels into the line store and issues one job per output pixel. Uses dwld_pkg.
module dwld_front
	import dwld_pkg::*;
#(
	parameter int SB   = 11,
	parameter int SLB  = 5,
	parameter int DB   = 4,
	parameter int RING = 20,
	parameter int JW   = 16 + SB + SLB + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DB-1:0]      d,
	input  logic [SB:0]        w,
	input  logic [15:0]        h,
	input  logic               push,
	input  logic               action,
	input  logic [7:0]         pixel_value,
	output logic               full,
	output logic               wr_en,
	output logic [SLB+SB-1:0]  wr_addr,
	output logic [7:0]         wr_data,
	output logic               job_push,
	output logic [JW-1:0]      job_data,
	input  logic               job_full
);
	logic [15:0]    in_line_q, emit_line_q;
	logic [SB-1:0]  in_sample_q, emit_sample_q;
	logic [SLB-1:0] wr_slot_q, em_slot_q, wr_slot_nx;
	logic           accept, done_in, last, in_eol, em_eol;
	logic [SB-1:0]  wmax, ins, es;

	assign full    = job_full;
	assign accept  = push & ~job_full;
	assign wmax    = SB'(w - 1'b1);
	assign done_in = (in_line_q >= h);
	assign ins     = ({1'b0, in_sample_q} >= w) ? wmax : in_sample_q;
	assign es      = ({1'b0, emit_sample_q} >= w) ? wmax : emit_sample_q;
	assign in_eol  = (ins == wmax);
	assign em_eol  = (es == wmax);
	assign last    = (emit_line_q >= h - 16'd1) && em_eol;

	assign wr_en   = accept & ~done_in & (action == ACT_PIXEL);
	assign wr_addr = {wr_slot_q, ins};
	assign wr_data = pixel_value;

	assign job_push = accept & (done_in | ((action == ACT_PIXEL) && (in_line_q >= 16'(d))));
	assign job_data = {emit_line_q, es, em_slot_q, last};

	always_comb begin
		wr_slot_nx = wr_slot_q;
		if (wr_en && in_eol) begin
			wr_slot_nx = (32'(wr_slot_q) == RING - 1) ? '0 : wr_slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q     <= '0;
			in_sample_q   <= '0;
			emit_line_q   <= '0;
			emit_sample_q <= '0;
			wr_slot_q     <= '0;
			em_slot_q     <= '0;
		end else begin
			wr_slot_q <= wr_slot_nx;
			if (wr_en) begin
				if (in_eol) begin
					in_sample_q <= '0;
					in_line_q   <= in_line_q + 16'd1;
				end else begin
					in_sample_q <= ins + 1'b1;
				end
			end
			if (job_push) begin
				if (last) begin
					in_line_q     <= '0;
					in_sample_q   <= '0;
					emit_line_q   <= '0;
					emit_sample_q <= '0;
					em_slot_q     <= wr_slot_nx;
				end else if (em_eol) begin
					emit_sample_q <= '0;
					emit_line_q   <= emit_line_q + 16'd1;
					em_slot_q     <= (32'(em_slot_q) == RING - 1) ? '0 : em_slot_q + 1'b1;
				end else begin
					emit_sample_q <= es + 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/core/dwld_back.sv =====
// Back part: holds the line store and scans the diamond window of each job,
// latest position first, one position per cycle. Feeds the result register.
module dwld_back #(
	parameter int SB   = 11,
	parameter int SLB  = 5,
	parameter int DB   = 4,
	parameter int RING = 20,
	parameter int JW   = 16 + SB + SLB + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DB-1:0]     d,
	input  logic [SB:0]       w,
	input  logic [15:0]       h,
	input  logic              wr_en,
	input  logic [SLB+SB-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              job_empty,
	input  logic [JW-1:0]     job_data,
	output logic              job_pop,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_value,
	output logic [15:0]       out_line,
	output logic [SB-1:0]     out_sample,
	output logic              frame_last
);
	localparam int DEPTH = RING << SB;
	localparam int RW    = 18 + DB;
	localparam int CW    = SB + DB + 2;
	localparam int SW    = SLB + DB + 2;
	localparam logic signed [DB:0] UNIT = (DB+1)'(1);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	logic [7:0]          mem [DEPTH];
	logic [7:0]          rd_s1;
	logic                valid_s1, final_s1;
	state_t              state_q;
	logic [15:0]         line_q;
	logic [SB-1:0]       sample_q;
	logic [SLB-1:0]      slot_q;
	logic                last_q, issue_q, res_valid_q;
	logic [7:0]          value_q;
	logic signed [DB:0]  dr_q, dc_q, sd, abs_dr, span, dr_nx, abs_nx, span_nx;
	logic signed [RW-1:0] row;
	logic signed [CW-1:0] col;
	logic signed [SW-1:0] rs, rs_w;
	logic                inb, final_pos;
	logic [SLB+SB-1:0]   rd_addr;

	assign sd        = $signed({1'b0, d});
	assign abs_dr    = (dr_q < 0) ? -dr_q : dr_q;
	assign span      = sd - abs_dr;
	assign dr_nx     = dr_q - UNIT;
	assign abs_nx    = (dr_nx < 0) ? -dr_nx : dr_nx;
	assign span_nx   = sd - abs_nx;
	assign final_pos = (dr_q == -sd) && (dc_q == -span);

	assign row = $signed({{(RW-16){1'b0}}, line_q}) + RW'(dr_q);
	assign col = $signed({{(CW-SB){1'b0}}, sample_q}) + CW'(dc_q);
	assign inb = (row >= 0) && (row < $signed({{(RW-16){1'b0}}, h}))
		&& (col >= 0) && (col < $signed({{(CW-SB-1){1'b0}}, w}));

	assign rs = $signed({{(SW-SLB){1'b0}}, slot_q}) + SW'(dr_q);
	always_comb begin
		rs_w = rs;
		if (rs < 0) begin
			rs_w = rs + SW'(RING);
		end else if (rs >= SW'(RING)) begin
			rs_w = rs - SW'(RING);
		end
	end
	assign rd_addr = {SLB'(rs_w), SB'(col)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	assign job_pop    = (state_q == ST_IDLE) && !job_empty && !res_valid_q;
	assign empty      = ~res_valid_q;
	assign out_value  = value_q;
	assign out_line   = line_q;
	assign out_sample = sample_q;
	assign frame_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			issue_q     <= 1'b0;
			valid_s1    <= 1'b0;
			final_s1    <= 1'b0;
			line_q      <= '0;
			sample_q    <= '0;
			slot_q      <= '0;
			last_q      <= 1'b0;
			value_q     <= '0;
			dr_q        <= '0;
			dc_q        <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						{line_q, sample_q, slot_q, last_q} <= job_data;
						dr_q     <= sd;
						dc_q     <= '0;
						issue_q  <= 1'b1;
						valid_s1 <= 1'b0;
						final_s1 <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					valid_s1 <= issue_q & inb;
					final_s1 <= issue_q & final_pos;
					if (issue_q) begin
						if (final_pos) begin
							issue_q <= 1'b0;
						end else if (dc_q == -span) begin
							dr_q <= dr_nx;
							dc_q <= span_nx;
						end else begin
							dc_q <= dc_q - UNIT;
						end
					end
					if ((valid_s1 && rd_s1 != 8'd0) || final_s1) begin
						value_q     <= valid_s1 ? rd_s1 : 8'd0;
						res_valid_q <= 1'b1;
						issue_q     <= 1'b0;
						valid_s1    <= 1'b0;
						final_s1    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/diamond_window_label_dilation.sv =====
// Top level of the diamond window label dilation block.
// Holds the configuration registers and connects dwld_front, dwld_queue and dwld_back.
//
// Input items (action, pixel_value) are pushed in raster order; a transfer takes
// place when push is high and full is low. A pixel item writes the line store;
// once d lines are in, each pixel item, and each flush item after the frame's
// last pixel, yields one output pixel d lines behind. Results wait on the result
// ports while empty is low; a transfer takes place when pop is high.
// The front takes one item per cycle while the two-entry job queue has room.
// The back scans the diamond one position per cycle from the single read port
// of the line store and ends a job at the first position with a nonzero label
// or at the last position of the diamond, so that scan sets the sustained rate.
// A stalled receiver holds the result register, then fills the queue, and then
// raises full. Reset clears all counters and the queue; the line store is not
// cleared, since every entry read is written earlier in the same frame.
// Configuration is written over the APB port at byte addresses 0, 4 and 8; the user
// must write it only while the block is idle, as the block itself does not enforce it.
module diamond_window_label_dilation
	import dwld_pkg::*;
#(
	parameter int MAX_DIST    = 8,
	parameter int MAX_SAMPLES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  pixel_value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_value,
	output logic [15:0] out_line,
	output logic [10:0] out_sample,
	output logic        frame_last
);
	localparam int SB   = $clog2(MAX_SAMPLES);
	localparam int RING = 2 * MAX_DIST + 4;
	localparam int SLB  = $clog2(RING);
	localparam int DB   = $clog2(MAX_DIST + 1);
	localparam int JW   = 16 + SB + SLB + 1;

	logic [3:0]        dist_q;
	logic [11:0]       samples_q;
	logic [15:0]       lines_q;
	logic [DB-1:0]     eff_d;
	logic [SB:0]       eff_w;
	logic [15:0]       eff_h;
	logic              cfg_wr;
	logic              wr_en, job_push, job_full, job_pop, job_empty;
	logic [SLB+SB-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [JW-1:0]     job_in, job_out;
	logic [SB-1:0]     sample_full;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q    <= 4'd0;
			samples_q <= 12'd2048;
			lines_q   <= 16'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DIST:    dist_q    <= pwdata[3:0];
				REG_SAMPLES: samples_q <= pwdata[11:0];
				REG_LINES:   lines_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIST:    prdata = {28'd0, dist_q};
			REG_SAMPLES: prdata = {20'd0, samples_q};
			REG_LINES:   prdata = {16'd0, lines_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign eff_d = (32'(dist_q) > MAX_DIST) ? DB'(MAX_DIST) : DB'(dist_q);
	assign eff_w = (samples_q == 12'd0) ? (SB+1)'(1)
		: ((32'(samples_q) > MAX_SAMPLES) ? (SB+1)'(MAX_SAMPLES) : (SB+1)'(samples_q));
	assign eff_h = (lines_q == 16'd0) ? 16'd1 : lines_q;

	dwld_front #(.SB(SB), .SLB(SLB), .DB(DB), .RING(RING), .JW(JW)) u_front (
		.clk, .arst_n,
		.d(eff_d), .w(eff_w), .h(eff_h),
		.push, .action, .pixel_value, .full,
		.wr_en, .wr_addr, .wr_data,
		.job_push, .job_data(job_in), .job_full
	);

	dwld_queue #(.W(JW), .DEPTH(2)) u_queue (
		.clk, .arst_n,
		.push(job_push), .wdata(job_in), .full(job_full),
		.pop(job_pop), .rdata(job_out), .empty(job_empty)
	);

	dwld_back #(.SB(SB), .SLB(SLB), .DB(DB), .RING(RING), .JW(JW)) u_back (
		.clk, .arst_n,
		.d(eff_d), .w(eff_w), .h(eff_h),
		.wr_en, .wr_addr, .wr_data,
		.job_empty, .job_data(job_out), .job_pop,
		.empty, .pop, .out_value, .out_line, .out_sample(sample_full), .frame_last
	);

	assign out_sample = 11'(sample_full);
endmodule

// ===== tb/sv/dwld_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the diamond window label dilation block: watches the register
// port and both queue channels, predicts each output pixel and compares it.
// Depends on dwld_pkg for register indexes and action codes.
module dwld_checker
	import dwld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic        action,
	input  logic [7:0]  pixel_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_value,
	input  logic [15:0] out_line,
	input  logic [10:0] out_sample,
	input  logic        frame_last,
	output int          errors,
	output int          pending,
	output int          results
);
	localparam int MAXD  = 8;
	localparam int MAXW  = 2048;
	localparam int LINES = 2 * MAXD + 1;

	typedef struct packed {
		logic [7:0]  value;
		logic [15:0] line;
		logic [10:0] sample;
		logic        last;
	} out_pixel_t;

	logic [7:0]  label_store [0:LINES*MAXW-1];
	int unsigned in_row, in_col, out_row, out_col;
	logic [3:0]  radius_reg;
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	out_pixel_t  dilated_q [$];

	function automatic int store_index(int row, int col);
		return (row % LINES) * MAXW + (col % MAXW);
	endfunction

	function automatic logic [7:0] diamond_label(int r, int c, int d, int w, int h);
		int span;
		int row;
		int col;
		for (int dr = d; dr >= -d; dr--) begin
			row = r + dr;
			if (row < 0 || row >= h) continue;
			span = d - (dr < 0 ? -dr : dr);
			for (int dc = span; dc >= -span; dc--) begin
				col = c + dc;
				if (col < 0 || col >= w) continue;
				if (label_store[store_index(row, col)] != 0)
					return label_store[store_index(row, col)];
			end
		end
		return 8'd0;
	endfunction

	function automatic out_pixel_t next_output(int d, int w, int h);
		out_pixel_t o;
		if (out_col >= w) out_col = w - 1;
		o.value  = diamond_label(out_row, out_col, d, w, h);
		o.line   = out_row[15:0];
		o.sample = out_col[10:0];
		o.last   = (out_row >= h - 1) && (out_col == w - 1);
		if (o.last) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
		end else if (out_col == w - 1) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return o;
	endfunction

	task automatic dilate_step(logic act, logic [7:0] pix);
		int d;
		int w;
		int h;
		int row;
		d = (radius_reg > MAXD) ? MAXD : radius_reg;
		w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		if (in_row >= h) begin
			dilated_q.push_back(next_output(d, w, h));
			return;
		end
		if (act != ACT_PIXEL) return;
		if (in_col >= w) in_col = w - 1;
		row = in_row;
		label_store[store_index(in_row, in_col)] = pix;
		if (in_col == w - 1) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (row >= d) dilated_q.push_back(next_output(d, w, h));
	endtask

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	initial begin
		for (int i = 0; i < LINES * MAXW; i++) label_store[i] = 8'd0;
	end

	always @(posedge clk or negedge arst_n) begin
		out_pixel_t e;
		if (!arst_n) begin
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			radius_reg = 4'd0;
			width_reg = 12'd2048;
			height_reg = 16'd1;
			dilated_q.delete();
			errors = 0;
			results = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_DIST:    radius_reg = pwdata[3:0];
					REG_SAMPLES: width_reg = pwdata[11:0];
					REG_LINES:   height_reg = pwdata[15:0];
					default: ;
				endcase
			end
			if (push && !full) dilate_step(action, pixel_value);
			if (pop && !empty) begin
				results++;
				if (dilated_q.size() == 0) begin
					report("unexpected output pixel count", results, results - 1);
				end else begin
					e = dilated_q.pop_front();
					if (out_value !== e.value) report("out_value", out_value, e.value);
					if (out_line !== e.line) report("out_line", out_line, e.line);
					if (out_sample !== e.sample) report("out_sample", out_sample, e.sample);
					if (frame_last !== e.last) report("frame_last", frame_last, e.last);
				end
			end
		end
		pending = dilated_q.size();
	end
endmodule

// ===== tb/sv/tb_diamond_window_label_dilation.sv =====
`timescale 1ns / 1ps
// Top of the testbench: drives images, flush items and register writes into the
// dilation block and gives the verdict. Depends on dwld_pkg and dwld_checker.
module tb_diamond_window_label_dilation;
	import dwld_pkg::*;

	localparam int IDLE_PCT    = 27;
	localparam int DRAIN_WAIT  = 200;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0, full, action = ACT_PIXEL;
	logic [7:0]  pixel_value = '0;
	logic        empty, pop = 1'b0;
	logic [7:0]  out_value;
	logic [15:0] out_line;
	logic [10:0] out_sample;
	logic        frame_last;
	int          errors, pending, results;
	int          items_sent = 0, frames_sent = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0, hold_req = 1'b0, held = 1'b0;

	always #5 clk = ~clk;

	diamond_window_label_dilation dut (.*);

	dwld_checker u_checker (.*);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("tb_diamond_window_label_dilation: FAIL");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send(logic act, logic [7:0] pix);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		pixel_value <= pix;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	task automatic reg_write(logic [1:0] idx, int unsigned value);
		push <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic configure(int unsigned d, int unsigned w, int unsigned h);
		settle();
		reg_write(REG_DIST, d);
		reg_write(REG_SAMPLES, w);
		reg_write(REG_LINES, h);
	endtask

	function automatic logic [7:0] rand_label(int zero_pct);
		if ($urandom_range(99) < zero_pct) return 8'd0;
		return 8'($urandom_range(255));
	endfunction

	// One image with optional stray flush items inside, then the drain items,
	// each a flush or a pixel whose value is ignored.
	task automatic image(int unsigned d, int unsigned w, int unsigned h, int zero_pct,
			bit noise);
		int de;
		int we;
		int he;
		int dn;
		de = (d > 8) ? 8 : d;
		we = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
		he = (h == 0) ? 1 : h;
		dn = (de < he) ? de : he;
		for (int i = 0; i < we * he; i++) begin
			if (noise && $urandom_range(9) == 0) send(ACT_FLUSH, 8'($urandom_range(255)));
			send(ACT_PIXEL, rand_label(zero_pct));
		end
		for (int i = 0; i < dn * we; i++)
			send($urandom_range(1) ? ACT_FLUSH : ACT_PIXEL, 8'($urandom_range(255)));
		frames_sent++;
	endtask

	initial begin
		int unsigned d;
		int unsigned w;
		int unsigned h;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(0, 4, 2);
		send(ACT_FLUSH, 8'hFF);
		send(ACT_PIXEL, 8'd0);
		send(ACT_PIXEL, 8'd255);
		send(ACT_PIXEL, 8'd1);
		send(ACT_PIXEL, 8'd128);
		send(ACT_PIXEL, 8'd127);
		send(ACT_PIXEL, 8'd0);
		send(ACT_PIXEL, 8'd85);
		send(ACT_PIXEL, 8'd170);
		configure(1, 3, 2);
		image(1, 3, 2, 50, 1'b1);
		configure(15, 3, 0);
		image(15, 3, 0, 30, 1'b0);
		configure(2, 0, 3);
		image(2, 0, 3, 50, 1'b0);
		configure(0, 4095, 65535);
		configure(0, 600, 1);
		calm = 1'b1;
		image(0, 600, 1, 50, 1'b0);
		calm = 1'b0;
		configure(8, 12, 10);
		image(8, 12, 10, 95, 1'b0);

		while (items_sent < 1550) begin
			d = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
			w = $urandom_range(16, 1);
			h = $urandom_range(8, 1);
			configure(d, w, h);
			if (!held && frames_sent >= 12) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			calm = (frames_sent >= 20 && frames_sent < 24);
			repeat ($urandom_range(2, 1))
				image(d, w, h, $urandom_range(95), $urandom_range(3) == 0);
		end
		calm = 1'b0;
		settle();

		$display("Sent %0d items in %0d images and checked %0d output pixels.",
			items_sent, frames_sent, results);
		$display("Radii 0 to 15, widths 0 to 4095 and heights 0 to 65535 were programmed.");
		if (errors == 0 && pending == 0) begin
			$display("tb_diamond_window_label_dilation: PASS");
		end else begin
			$display("%0d mismatches, %0d output pixels missing", errors, pending);
			$display("tb_diamond_window_label_dilation: FAIL");
		end
		$finish;
	end
endmodule
